/* sv/tlik_pkg.sv */
// Shared types, status codes and the arctangent table of the two-link IK unit.
package tlik_pkg;

  localparam int ANG_BITS = 40;
  localparam int ZW = 44;
  localparam int GUARD = 16;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_DIST = 2'd1;
  localparam logic [1:0] STATUS_WS = 2'd2;

  typedef struct packed {
    logic               valid;
    logic [1:0]         status;
    logic signed [16:0] tx;
    logic signed [16:0] ty;
  } meta_t;

  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
    logic signed [ZW-1:0] val;
    case (idx)
      5'd0: val = 44'sd863554413089;
      5'd1: val = 44'sd509785937287;
      5'd2: val = 44'sd269356888665;
      5'd3: val = 44'sd136729762476;
      5'd4: val = 44'sd68630207382;
      5'd5: val = 44'sd34348560106;
      5'd6: val = 44'sd17178471287;
      5'd7: val = 44'sd8589759836;
      5'd8: val = 44'sd4294945451;
      5'd9: val = 44'sd2147480917;
      5'd10: val = 44'sd1073741483;
      5'd11: val = 44'sd536870869;
      5'd12: val = 44'sd268435451;
      5'd13: val = 44'sd134217727;
      default: val = ZW'(64'd1 << (ANG_BITS - int'(idx)));
    endcase
    return val;
  endfunction

endpackage

/* sv/two_link_inverse_kinematics_unit.sv */
// Top level of the two-link planar arm inverse kinematics pipeline.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-----------------------------------------------
//   request   | start, busy          | pos_x_i, pos_y_i, axis_sel_i, move_dist_i
//   result    | done_o (strobe)      | status_o, shoulder_angle_o, elbow_angle_o
//
// A new request is taken in every cycle; busy is never raised.
// Each result passes through the front end, one square root cell per result bit
// and one CORDIC cell per stage.
// Reset clears only the pipeline's metadata registers (valid, status, target) and done_o.
// The receiver cannot stall; every result is shown for exactly one cycle.
module two_link_inverse_kinematics_unit #(
  parameter int CORDIC_STAGES = 14,
  parameter int FRAC_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic               axis_sel_i,
  input  logic signed [15:0] move_dist_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [15:0] shoulder_angle_o,
  output logic signed [15:0] elbow_angle_o
);
  import tlik_pkg::*;

  localparam int IW = (FRAC_BITS + 4 > 17) ? FRAC_BITS + 4 : 17;
  localparam int CW = IW + GUARD + 3;
  localparam int RW = (2 * FRAC_BITS + 6 > 35) ? 2 * FRAC_BITS + 6 : 35;
  localparam int NW = RW + 1;
  localparam int VW = FRAC_BITS + 3;
  localparam int KSH = FRAC_BITS + 6;
  localparam int RECW = FRAC_BITS + 4;
  localparam int PW = VW + RECW;
  localparam int CWID = FRAC_BITS + 2;
  localparam int SW = 2 * FRAC_BITS + 2;
  localparam int SQW = 2 * CWID;
  localparam int NSQ = FRAC_BITS + 1;
  localparam int ZW1 = ZW + 1;

  localparam logic [RECW-1:0] RECIP = RECW'((64'd1 << KSH) / 64'd6);
  localparam logic signed [23:0] HALF = 24'sd1 <<< (FRAC_BITS - 1);
  localparam logic [RW-1:0] R2_HI = RW'(49) << (2 * FRAC_BITS - 2);
  localparam logic [RW-1:0] R2_LO = RW'(1) << (2 * FRAC_BITS - 2);
  localparam logic [RW-1:0] R2_MID = RW'(25) << (2 * FRAC_BITS - 2);
  localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] ONE_SQ = SW'(1) << (2 * FRAC_BITS);
  localparam logic signed [IW-1:0] FOUR = IW'(4) <<< FRAC_BITS;
  localparam logic signed [ZW:0] RND = ZW1'(1) <<< (ANG_BITS - FRAC_BITS - 1);
  localparam logic signed [ZW:0] SAT_HI = ZW1'(32767);
  localparam logic signed [ZW:0] SAT_LO = ZW1'(-32768);

  function automatic logic signed [15:0] to_q(input logic signed [ZW-1:0] ang);
    logic signed [ZW:0] t;
    logic signed [ZW:0] sh;
    logic signed [15:0] r;
    t = ZW1'(ang) + RND;
    sh = t >>> (ANG_BITS - FRAC_BITS);
    if (sh > SAT_HI) begin
      r = 16'sh7fff;
    end else if (sh < SAT_LO) begin
      r = 16'sh8000;
    end else begin
      r = sh[15:0];
    end
    return r;
  endfunction

  logic               v0_q;
  logic signed [15:0] px0_q, py0_q, d0_q;
  logic               ax0_q;

  meta_t              m1_d, m1_q;
  logic               bad1_d, bad1_q;
  logic signed [23:0] d_ext;

  meta_t              m2_q;
  logic               bad2_q;
  logic signed [33:0] sqx_full, sqy_full;
  logic [32:0]        sqx_q, sqy_q;

  meta_t              m3_d, m3_q;
  logic [RW-1:0]      r2;
  logic signed [NW-1:0] ndiff;
  logic [NW-1:0]      nmag;
  logic [VW-1:0]      v3_d, v3_q;
  logic               neg3_q;

  meta_t              m4_q;
  logic [PW-1:0]      prod4_q;
  logic [VW-1:0]      v4_q;
  logic               neg4_q;

  meta_t              m5_q;
  logic [VW-1:0]      q0, qc;
  logic [VW+2:0]      q6, rem;
  logic signed [CWID-1:0] c5_d, c5_q;

  meta_t              m6_q;
  logic signed [SQW-1:0] csq_full;
  logic [SW-1:0]      csq6_q;
  logic signed [CWID-1:0] c6_q;

  meta_t                  sq_meta [NSQ+1];
  logic [SW-1:0]          sq_rad [NSQ+1];
  logic [SW-1:0]          sq_res [NSQ+1];
  logic signed [CWID-1:0] sq_c [NSQ+1];

  logic [FRAC_BITS:0]     s_w;
  logic signed [CWID-1:0] c_w;
  logic signed [IW-1:0]   ay, ax, by, bx, cy, cx, c_ext, s_ext;

  meta_t                cm [CORDIC_STAGES+1];
  logic signed [CW-1:0] cxs [CORDIC_STAGES+1][3];
  logic signed [CW-1:0] cys [CORDIC_STAGES+1][3];
  logic signed [ZW-1:0] czs [CORDIC_STAGES+1][3];

  logic signed [ZW-1:0] a1, a2;
  meta_t                mf;
  logic                 done_q;
  logic [1:0]           status_q;
  logic signed [15:0]   sh_q, el_q;

  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    px0_q <= pos_x_i;
    py0_q <= pos_y_i;
    d0_q <= move_dist_i;
    ax0_q <= axis_sel_i;
  end

  // Target position and distance check.
  always_comb begin
    d_ext = 24'(d0_q);
    bad1_d = (d_ext > HALF) || (d_ext < -HALF);
    m1_d.valid = v0_q;
    m1_d.status = STATUS_OK;
    m1_d.tx = 17'(px0_q) + (ax0_q ? 17'sd0 : 17'(d0_q));
    m1_d.ty = 17'(py0_q) + (ax0_q ? 17'(d0_q) : 17'sd0);
  end

  // Squares.
  always_comb begin
    sqx_full = m1_q.tx * m1_q.tx;
    sqy_full = m1_q.ty * m1_q.ty;
  end

  // Radius check and magnitude of the cosine numerator.
  always_comb begin
    r2 = RW'(sqx_q) + RW'(sqy_q);
    m3_d = m2_q;
    if (bad2_q) begin
      m3_d.status = STATUS_DIST;
    end else if ((r2 > R2_HI) || (r2 < R2_LO)) begin
      m3_d.status = STATUS_WS;
    end else begin
      m3_d.status = STATUS_OK;
    end
    ndiff = $signed({1'b0, r2}) - $signed({1'b0, R2_MID});
    nmag = ndiff[NW-1] ? NW'(-ndiff) : NW'(ndiff);
    v3_d = VW'(nmag >> FRAC_BITS);
  end

  // Quotient by six with one correction step, then clamp and sign.
  always_comb begin
    q0 = VW'(prod4_q >> KSH);
    q6 = ((VW+3)'(q0) << 2) + ((VW+3)'(q0) << 1);
    rem = (VW+3)'(v4_q) - q6;
    qc = q0 + ((rem >= (VW+3)'(6)) ? VW'(1) : VW'(0));
    if (qc > ONE_V) begin
      qc = ONE_V;
    end
    c5_d = neg4_q ? -CWID'(qc) : CWID'(qc);
  end

  assign csq_full = c5_q * c5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
      m2_q <= '0;
      m3_q <= '0;
      m4_q <= '0;
      m5_q <= '0;
      m6_q <= '0;
    end else begin
      m1_q <= m1_d;
      m2_q <= m1_q;
      m3_q <= m3_d;
      m4_q <= m3_q;
      m5_q <= m4_q;
      m6_q <= m5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bad1_q <= bad1_d;
    bad2_q <= bad1_q;
    sqx_q <= sqx_full[32:0];
    sqy_q <= sqy_full[32:0];
    v3_q <= v3_d;
    neg3_q <= ndiff[NW-1];
    prod4_q <= PW'(v3_q) * PW'(RECIP);
    v4_q <= v3_q;
    neg4_q <= neg3_q;
    c5_q <= c5_d;
    csq6_q <= SW'(csq_full);
    c6_q <= c5_q;
  end

  // Square root of one minus the cosine squared, one result bit per cell.
  assign sq_meta[0] = m6_q;
  assign sq_rad[0] = ONE_SQ - csq6_q;
  assign sq_res[0] = '0;
  assign sq_c[0] = c6_q;

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    tlik_sqrt_cell #(
      .SW(SW),
      .CWID(CWID),
      .BIT_POS(2 * (FRAC_BITS - j))
    ) u_cell (
      .clk_i(clk_i),
      .rst_ni(rst_ni),
      .meta_i(sq_meta[j]),
      .rad_i(sq_rad[j]),
      .res_i(sq_res[j]),
      .c_i(sq_c[j]),
      .meta_o(sq_meta[j+1]),
      .rad_o(sq_rad[j+1]),
      .res_o(sq_res[j+1]),
      .c_o(sq_c[j+1])
    );
  end

  always_comb begin
    s_w = sq_res[NSQ][FRAC_BITS:0];
    c_w = sq_c[NSQ];
    s_ext = IW'(s_w);
    c_ext = IW'(c_w);
    ay = s_ext;
    ax = c_ext;
    by = IW'(sq_meta[NSQ].ty);
    bx = IW'(sq_meta[NSQ].tx);
    cy = (s_ext <<< 1) + s_ext;
    cx = FOUR + (c_ext <<< 1) + c_ext;
  end

  tlik_cordic_prep #(
    .IW(IW),
    .CW(CW)
  ) u_prep (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .meta_i(sq_meta[NSQ]),
    .ay_i(ay),
    .ax_i(ax),
    .by_i(by),
    .bx_i(bx),
    .cy_i(cy),
    .cx_i(cx),
    .meta_o(cm[0]),
    .x_o(cxs[0]),
    .y_o(cys[0]),
    .z_o(czs[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    tlik_cordic_cell #(
      .CW(CW),
      .STAGE(k)
    ) u_cell (
      .clk_i(clk_i),
      .rst_ni(rst_ni),
      .meta_i(cm[k]),
      .x_i(cxs[k]),
      .y_i(cys[k]),
      .z_i(czs[k]),
      .meta_o(cm[k+1]),
      .x_o(cxs[k+1]),
      .y_o(cys[k+1]),
      .z_o(czs[k+1])
    );
  end

  // Angle difference, rounding and result register.
  always_comb begin
    mf = cm[CORDIC_STAGES];
    a2 = czs[CORDIC_STAGES][0];
    a1 = czs[CORDIC_STAGES][1] - czs[CORDIC_STAGES][2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mf.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= mf.status;
    if (mf.status == STATUS_OK) begin
      sh_q <= to_q(a1);
      el_q <= to_q(a2);
    end else begin
      sh_q <= '0;
      el_q <= '0;
    end
  end

  assign done_o = done_q;
  assign status_o = status_q;
  assign shoulder_angle_o = sh_q;
  assign elbow_angle_o = el_q;
endmodule

/* sv/tlik_sqrt_cell.sv */
// One digit step of the pipelined integer square root.
module tlik_sqrt_cell #(
  parameter int SW = 26,
  parameter int CWID = 14,
  parameter int BIT_POS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tlik_pkg::meta_t        meta_i,
  input  logic [SW-1:0]          rad_i,
  input  logic [SW-1:0]          res_i,
  input  logic signed [CWID-1:0] c_i,
  output tlik_pkg::meta_t        meta_o,
  output logic [SW-1:0]          rad_o,
  output logic [SW-1:0]          res_o,
  output logic signed [CWID-1:0] c_o
);
  import tlik_pkg::*;

  localparam logic [SW-1:0] BIT = SW'(1) << BIT_POS;

  logic [SW-1:0] trial;
  logic [SW-1:0] rad_d, rad_q;
  logic [SW-1:0] res_d, res_q;
  logic signed [CWID-1:0] c_q;
  meta_t meta_q;

  always_comb begin
    trial = res_i + BIT;
    if (rad_i >= trial) begin
      rad_d = rad_i - trial;
      res_d = (res_i >> 1) + BIT;
    end else begin
      rad_d = rad_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else begin
      meta_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    res_q <= res_d;
    c_q <= c_i;
  end

  assign meta_o = meta_q;
  assign rad_o = rad_q;
  assign res_o = res_q;
  assign c_o = c_q;
endmodule

/* sv/tlik_cordic_prep.sv */
// Guard scaling and quadrant fold of the three arctangent lanes.
module tlik_cordic_prep #(
  parameter int IW = 17,
  parameter int CW = 36
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tlik_pkg::meta_t                  meta_i,
  input  logic signed [IW-1:0]             ay_i,
  input  logic signed [IW-1:0]             ax_i,
  input  logic signed [IW-1:0]             by_i,
  input  logic signed [IW-1:0]             bx_i,
  input  logic signed [IW-1:0]             cy_i,
  input  logic signed [IW-1:0]             cx_i,
  output tlik_pkg::meta_t                  meta_o,
  output logic signed [CW-1:0]             x_o [3],
  output logic signed [CW-1:0]             y_o [3],
  output logic signed [tlik_pkg::ZW-1:0]   z_o [3]
);
  import tlik_pkg::*;

  localparam logic signed [ZW-1:0] HALF_PI = atan_tab(5'd0) <<< 1;

  logic signed [IW-1:0] yin [3];
  logic signed [IW-1:0] xin [3];
  logic signed [CW-1:0] xs [3];
  logic signed [CW-1:0] ys [3];
  logic signed [CW-1:0] x_d [3];
  logic signed [CW-1:0] y_d [3];
  logic signed [ZW-1:0] z_d [3];
  logic signed [CW-1:0] x_q [3];
  logic signed [CW-1:0] y_q [3];
  logic signed [ZW-1:0] z_q [3];
  meta_t meta_q;

  assign yin[0] = ay_i;
  assign xin[0] = ax_i;
  assign yin[1] = by_i;
  assign xin[1] = bx_i;
  assign yin[2] = cy_i;
  assign xin[2] = cx_i;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      xs[l] = CW'(xin[l]) <<< GUARD;
      ys[l] = CW'(yin[l]) <<< GUARD;
      if (xs[l][CW-1]) begin
        if (!ys[l][CW-1]) begin
          x_d[l] = ys[l];
          y_d[l] = -xs[l];
          z_d[l] = HALF_PI;
        end else begin
          x_d[l] = -ys[l];
          y_d[l] = xs[l];
          z_d[l] = -HALF_PI;
        end
      end else begin
        x_d[l] = xs[l];
        y_d[l] = ys[l];
        z_d[l] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else begin
      meta_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign meta_o = meta_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

/* sv/tlik_cordic_cell.sv */
// One vectoring micro-rotation for the three arctangent lanes.
module tlik_cordic_cell #(
  parameter int CW = 36,
  parameter int STAGE = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tlik_pkg::meta_t                meta_i,
  input  logic signed [CW-1:0]           x_i [3],
  input  logic signed [CW-1:0]           y_i [3],
  input  logic signed [tlik_pkg::ZW-1:0] z_i [3],
  output tlik_pkg::meta_t                meta_o,
  output logic signed [CW-1:0]           x_o [3],
  output logic signed [CW-1:0]           y_o [3],
  output logic signed [tlik_pkg::ZW-1:0] z_o [3]
);
  import tlik_pkg::*;

  localparam logic signed [ZW-1:0] ANG = atan_tab(5'(STAGE));

  logic signed [CW-1:0] x_d [3];
  logic signed [CW-1:0] y_d [3];
  logic signed [ZW-1:0] z_d [3];
  logic signed [CW-1:0] x_q [3];
  logic signed [CW-1:0] y_q [3];
  logic signed [ZW-1:0] z_q [3];
  meta_t meta_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (!y_i[l][CW-1]) begin
        x_d[l] = x_i[l] + (y_i[l] >>> STAGE);
        y_d[l] = y_i[l] - (x_i[l] >>> STAGE);
        z_d[l] = z_i[l] + ANG;
      end else begin
        x_d[l] = x_i[l] - (y_i[l] >>> STAGE);
        y_d[l] = y_i[l] + (x_i[l] >>> STAGE);
        z_d[l] = z_i[l] - ANG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else begin
      meta_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign meta_o = meta_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

/* sv/tlik_checker.sv */
// Port-level checks of the two-link IK unit and their binding.
module tlik_checker #(
  parameter int CORDIC_STAGES = 14,
  parameter int FRAC_BITS = 12
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] pos_x_i,
  input logic signed [15:0] pos_y_i,
  input logic               axis_sel_i,
  input logic signed [15:0] move_dist_i,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic signed [15:0] shoulder_angle_o,
  input logic signed [15:0] elbow_angle_o
);
  import tlik_pkg::*;

  localparam int LAT = FRAC_BITS + CORDIC_STAGES + 10;
  localparam logic signed [23:0] HALF = 24'sd1 <<< (FRAC_BITS - 1);

  logic signed [23:0] d_ext;
  logic               dist_bad;

  assign d_ext = 24'(move_dist_i);
  assign dist_bad = (d_ext > HALF) || (d_ext < -HALF);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LAT done_o)
    else $error("request did not produce a result at the expected cycle");

  a_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && dist_bad |-> ##LAT (done_o && status_o == STATUS_DIST))
    else $error("out-of-range distance not reported");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != STATUS_OK |-> shoulder_angle_o == 16'sd0 && elbow_angle_o == 16'sd0)
    else $error("rejected request carries nonzero angles");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o == STATUS_OK || status_o == STATUS_DIST || status_o == STATUS_WS)
    else $error("unknown status code");
endmodule

bind two_link_inverse_kinematics_unit tlik_checker #(
  .CORDIC_STAGES(CORDIC_STAGES),
  .FRAC_BITS(FRAC_BITS)
) u_tlik_checker (.*);

/* tb/sv/tlik_ik_checker.sv */
// Checker for the two-link IK unit: predicts each request's result and compares it.
`timescale 1ns / 100ps
module tlik_ik_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic               axis_sel_i,
  input  logic signed [15:0] move_dist_i,
  input  logic               done_o,
  input  logic [1:0]         status_o,
  input  logic signed [15:0] shoulder_angle_o,
  input  logic signed [15:0] elbow_angle_o,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 ok_count_o,
  output int                 dist_count_o,
  output int                 ws_count_o
);
  import tlik_pkg::*;

  localparam int NUM_STAGES = 14;
  localparam int FRAC = 12;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] shoulder;
    logic signed [15:0] elbow;
  } joint_result_t;

  joint_result_t joint_queue[$];
  longint arctan_lut[24];

  function automatic longint arctan_inv_q56(longint k);
    longint p, total, n, term;
    bit neg;
    p = longint'((64'd1 << 56) / k);
    total = 0;
    n = 1;
    neg = 0;
    while (p > 0) begin
      term = p / n;
      total += neg ? -term : term;
      neg = !neg;
      n += 2;
      p = p / (k * k);
    end
    return total;
  endfunction

  function automatic longint vector_angle(longint y_in, longint x_in);
    longint x, y, z, tmp, dx, dy;
    if (x_in == 0 && y_in == 0) return 0;
    x = x_in * 65536;
    y = y_in * 65536;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        tmp = x; x = y; y = -tmp; z = 2 * arctan_lut[0];
      end else begin
        tmp = x; x = -y; y = tmp; z = -2 * arctan_lut[0];
      end
    end
    for (int i = 0; i < NUM_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_lut[i];
      end else begin
        x -= dx; y += dy; z -= arctan_lut[i];
      end
    end
    return z;
  endfunction

  function automatic longint int_sqrt(longint n_in);
    longint n, res, b;
    n = n_in;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] angle_to_q12(longint ang);
    longint v;
    v = (ang + (64'sd1 <<< 27)) >>> 28;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic joint_result_t predict_joints(logic signed [15:0] px,
      logic signed [15:0] py, logic ax, logic signed [15:0] step_len);
    joint_result_t r;
    longint tx, ty, r2, c, s, one, a1, a2, d;
    one = 64'sd1 <<< FRAC;
    r = '0;
    tx = longint'(px);
    ty = longint'(py);
    d = longint'(step_len);
    if (d > 2048 || d < -2048) begin
      r.status = STATUS_DIST;
      return r;
    end
    if (ax) ty += d;
    else tx += d;
    r2 = tx * tx + ty * ty;
    if (r2 > (64'sd49 <<< 22) || r2 < (64'sd1 <<< 22)) begin
      r.status = STATUS_WS;
      return r;
    end
    c = (r2 - (64'sd25 <<< 22)) / (64'sd6 <<< FRAC);
    if (c > one) c = one;
    if (c < -one) c = -one;
    s = int_sqrt(one * one - c * c);
    a2 = vector_angle(s, c);
    a1 = vector_angle(ty, tx) - vector_angle(3 * s, 4 * one + 3 * c);
    r.status = STATUS_OK;
    r.shoulder = angle_to_q12(a1);
    r.elbow = angle_to_q12(a2);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    longint q56[24];
    longint total, term;
    int n;
    bit neg;
    q56[0] = 4 * arctan_inv_q56(5) - arctan_inv_q56(239);
    for (int i = 1; i < 24; i++) begin
      total = 0;
      n = 1;
      neg = 0;
      while (n * i <= 56) begin
        term = (64'sd1 <<< (56 - n * i)) / n;
        total += neg ? -term : term;
        neg = !neg;
        n += 2;
      end
      q56[i] = total;
    end
    for (int i = 0; i < 24; i++) arctan_lut[i] = (q56[i] + (64'sd1 <<< 15)) >>> 16;
    fail_count_o = 0;
    ok_count_o = 0;
    dist_count_o = 0;
    ws_count_o = 0;
  end

  assign pending_o = joint_queue.size();

  always @(posedge clk_i) begin
    joint_result_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        want = predict_joints(pos_x_i, pos_y_i, axis_sel_i, move_dist_i);
        joint_queue.push_back(want);
        case (want.status)
          STATUS_OK: ok_count_o++;
          STATUS_DIST: dist_count_o++;
          default: ws_count_o++;
        endcase
      end
      if (done_o) begin
        if (joint_queue.size() == 0) begin
          report_mismatch("results outstanding", 1, 0);
        end else begin
          want = joint_queue.pop_front();
          if (status_o != want.status) report_mismatch("status", status_o, want.status);
          if (shoulder_angle_o != want.shoulder)
            report_mismatch("shoulder_angle", shoulder_angle_o, want.shoulder);
          if (elbow_angle_o != want.elbow)
            report_mismatch("elbow_angle", elbow_angle_o, want.elbow);
        end
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the two-link IK unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import tlik_pkg::*;

  localparam int LATENCY = 36;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQUESTS = 1030;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic busy_seen = 1'b0;
  logic signed [15:0] pos_x_i = '0;
  logic signed [15:0] pos_y_i = '0;
  logic axis_sel_i = 1'b0;
  logic signed [15:0] move_dist_i = '0;
  logic done_o;
  logic [1:0] status_o;
  logic signed [15:0] shoulder_angle_o;
  logic signed [15:0] elbow_angle_o;
  int fail_count, pending, ok_count, dist_count, ws_count;
  int cycle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  two_link_inverse_kinematics_unit u_dut (.*);

  tlik_ik_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .pos_x_i, .pos_y_i, .axis_sel_i, .move_dist_i,
    .done_o, .status_o, .shoulder_angle_o, .elbow_angle_o,
    .fail_count_o(fail_count), .pending_o(pending), .ok_count_o(ok_count),
    .dist_count_o(dist_count), .ws_count_o(ws_count)
  );

  always @(negedge clk_i) busy_seen <= busy;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Holds start high and waits for the edge that takes the request.
  task automatic send_request(logic signed [15:0] px, logic signed [15:0] py, logic ax,
      logic signed [15:0] step_len);
    start <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    axis_sel_i <= ax;
    move_dist_i <= step_len;
    do @(posedge clk_i); while (busy_seen);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Picks a reachable target and backs the start position off by the move.
  task automatic send_reachable();
    longint tx, ty, r2;
    logic signed [15:0] step_len;
    logic ax;
    do begin
      tx = longint'($signed($urandom_range(28672)) - 14336);
      ty = longint'($signed($urandom_range(28672)) - 14336);
      r2 = tx * tx + ty * ty;
    end while (r2 > (64'sd49 <<< 22) || r2 < (64'sd1 <<< 22));
    step_len = 16'($signed($urandom_range(4096)) - 2048);
    ax = 1'($urandom_range(1));
    if (ax) ty -= longint'(step_len);
    else tx -= longint'(step_len);
    send_request(tx[15:0], ty[15:0], ax, step_len);
  endtask

  initial begin
    int burst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(16'sd4096, 16'sd4096, 1'b0, 16'sd2048);
    send_request(16'sd4096, 16'sd4096, 1'b1, -16'sd2048);
    send_request(16'sd4096, 16'sd4096, 1'b0, 16'sd2049);
    send_request(16'sd4096, 16'sd4096, 1'b1, -16'sd2049);
    send_request(16'sd0, 16'sd0, 1'b0, 16'sh7fff);
    send_request(16'sd0, 16'sd0, 1'b1, -16'sd32768);
    send_request(16'sd0, 16'sd2048, 1'b0, 16'sd0);
    send_request(16'sd0, 16'sd2047, 1'b0, 16'sd0);
    send_request(16'sd14336, 16'sd0, 1'b1, 16'sd0);
    send_request(16'sd14337, 16'sd0, 1'b1, 16'sd0);
    send_request(-16'sd14336, 16'sd0, 1'b0, 16'sd0);
    send_request(-16'sd8192, 16'sd4096, 1'b0, 16'sd1000);
    send_request(-16'sd8192, -16'sd4096, 1'b1, -16'sd1000);
    send_request(16'sd4096, -16'sd8192, 1'b0, 16'sd2048);
    send_request(16'sd0, 16'sd0, 1'b0, 16'sd0);
    send_request(16'sh7fff, 16'sh7fff, 1'b1, 16'sd0);
    send_request(-16'sd32768, -16'sd32768, 1'b0, 16'sd0);
    send_request(16'sd10240, 16'sd0, 1'b0, 16'sd0);
    send_request(16'sd0, -16'sd6144, 1'b1, 16'sd0);
    idle_cycles(3);

    // The sender drains the pipeline once before the random part.
    while (pending != 0) @(posedge clk_i);

    for (int i = 0; i < RANDOM_REQUESTS; i += burst) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst; j++) begin
        if ($urandom_range(9) < 8) begin
          send_reachable();
        end else begin
          send_request(16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                       ($urandom_range(1) ? 16'($urandom) :
                        16'($signed($urandom_range(6000)) - 3000)));
        end
      end
      if ($urandom_range(3) != 0) idle_cycles($urandom_range(1, 12));
      if ($urandom_range(29) == 0) begin
        start <= 1'b0;
        while (pending != 0) @(posedge clk_i);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Covered %0d requests: %0d solved, %0d rejected on distance, %0d outside reach.",
             ok_count + dist_count + ws_count, ok_count, dist_count, ws_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
